>>> design/epwr_pkg.sv
package epwr_pkg;

    // Field widths
    localparam int COUNT_W   = 16;
    localparam int TIMEOUT_W = 20;
    localparam int ELAPSED_W = 21;
    localparam int ALT_W     = 20;
    localparam int SHIFT_W   = 3;
    localparam int FRAC_W    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 56;

    // Item kinds carried on the slave-side tuser
    localparam logic REQ_EDGE     = 1'b0;
    localparam logic REQ_OVERFLOW = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMER_TOP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_US   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ECHO_US  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ECHO_US  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_SHIFT = 3'd4;

    // Register reset values
    localparam logic [COUNT_W-1:0]   TIMER_TOP_RST    = 16'd65535;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_US_RST   = 20'd100000;
    localparam logic [COUNT_W-1:0]   MIN_ECHO_US_RST  = 16'd150;
    localparam logic [COUNT_W-1:0]   MAX_ECHO_US_RST  = 16'd15000;
    localparam logic [SHIFT_W-1:0]   FILTER_SHIFT_RST = 3'd2;

    typedef struct packed {
        logic [COUNT_W-1:0]   timer_top;
        logic [TIMEOUT_W-1:0] timeout_us;
        logic [COUNT_W-1:0]   min_echo_us;
        logic [COUNT_W-1:0]   max_echo_us;
        logic [SHIFT_W-1:0]   filter_shift;
    } cfg_t;

    typedef struct packed {
        logic [COUNT_W-1:0] capture_total;
        logic [ALT_W-1:0]   altitude;
        logic               too_close;
        logic               in_range;
        logic [COUNT_W-1:0] pulse_us;
    } result_t;

endpackage

>>> design/echo_pulse_width_ranger.sv
// A falling-edge item is held in the input register, then its result is written to the
// result register; a full result register that is not being emptied holds it in between.
// Throughput: one item per cycle while the result side takes items; the single-pass
// update of the capture state between the two registers sets that figure.
// Overflow items and rising edges give no result; each falling edge gives one.
// Reset (rst_n, asynchronous, active low) clears capture state and loads register defaults.
module echo_pulse_width_ranger (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [epwr_pkg::S_DATA_W-1:0]     s_tdata,   // [15:0] event_count
    input  logic                              s_tuser,   // [0] req_type
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] pulse_us, [16] in_range, [17] too_close, [37:18] altitude,
    // [53:38] capture_total, [55:54] zero
    output logic [epwr_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                              cfg_we,
    input  logic [epwr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [epwr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import epwr_pkg::*;

    cfg_t                cfg;
    logic                in_valid_reg;
    logic                in_type_reg;
    logic [COUNT_W-1:0]  in_count_reg;
    logic                advance;
    logic                res_valid;
    result_t             res;
    logic                out_valid_reg;
    result_t             out_data_reg;

    epwr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The held item moves on when the result register is free or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_type_reg  <= s_tuser;
            in_count_reg <= s_tdata[COUNT_W-1:0];
        end
    end

    epwr_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (advance),
        .req_type    (in_type_reg),
        .event_count (in_count_reg),
        .cfg         (cfg),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};

endmodule

>>> design/epwr_cfg.sv
module epwr_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [epwr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [epwr_pkg::CFG_DATA_W-1:0]   cfg_data,
    output epwr_pkg::cfg_t                    cfg
);
    import epwr_pkg::*;

    cfg_t cfg_reg;

    // Register file: one write per cycle, writes to unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timer_top    <= TIMER_TOP_RST;
            cfg_reg.timeout_us   <= TIMEOUT_US_RST;
            cfg_reg.min_echo_us  <= MIN_ECHO_US_RST;
            cfg_reg.max_echo_us  <= MAX_ECHO_US_RST;
            cfg_reg.filter_shift <= FILTER_SHIFT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TIMER_TOP:    cfg_reg.timer_top    <= cfg_data[COUNT_W-1:0];
                REG_TIMEOUT_US:   cfg_reg.timeout_us   <= cfg_data[TIMEOUT_W-1:0];
                REG_MIN_ECHO_US:  cfg_reg.min_echo_us  <= cfg_data[COUNT_W-1:0];
                REG_MAX_ECHO_US:  cfg_reg.max_echo_us  <= cfg_data[COUNT_W-1:0];
                REG_FILTER_SHIFT: cfg_reg.filter_shift <= cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/epwr_core.sv
module epwr_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           fire,
    input  logic                           req_type,
    input  logic [epwr_pkg::COUNT_W-1:0]   event_count,
    input  epwr_pkg::cfg_t                 cfg,
    output logic                           res_valid,
    output epwr_pkg::result_t              res
);
    import epwr_pkg::*;

    logic                  edge_phase_reg,  edge_phase_next;
    logic [COUNT_W-1:0]    rise_time_reg,   rise_time_next;
    logic [ELAPSED_W-1:0]  elapsed_us_reg,  elapsed_us_next;
    logic [ALT_W-1:0]      filtered_reg,    filtered_next;
    logic [COUNT_W-1:0]    capture_cnt_reg, capture_cnt_next;

    logic                  is_fall;
    logic [COUNT_W+1:0]    wrap_sum;
    logic [COUNT_W-1:0]    width;
    logic [ELAPSED_W:0]    elapsed_sum;
    logic [ELAPSED_W-1:0]  elapsed_sat;
    logic                  inr;
    logic                  close;
    logic [ALT_W-1:0]      sample;
    logic [ALT_W-1:0]      diff_up;
    logic [ALT_W-1:0]      diff_dn;
    logic [ALT_W:0]        diff_dn_rnd;
    logic [ALT_W-1:0]      filt_upd;
    logic [ALT_W:0]        round_mask;

    assign is_fall = (req_type == REQ_EDGE) && edge_phase_reg;

    // Pulse width, with wrap handling and saturation on both ends.
    always_comb
    begin
        wrap_sum = {2'b00, cfg.timer_top} - {2'b00, rise_time_reg}
                 + {2'b00, event_count};
        if (event_count > rise_time_reg)
        begin
            width = event_count - rise_time_reg;
        end
        else if (wrap_sum[COUNT_W+1])
        begin
            width = '0;
        end
        else if (wrap_sum[COUNT_W])
        begin
            width = '1;
        end
        else
        begin
            width = wrap_sum[COUNT_W-1:0];
        end
    end

    // Range checks against the limits.
    assign inr   = (width > cfg.min_echo_us) && (width < cfg.max_echo_us);
    assign close = (width <= cfg.min_echo_us);

    // Exponential filter; a downward step rounds toward minus infinity.
    always_comb
    begin
        sample      = {width, {FRAC_W{1'b0}}};
        diff_up     = sample - filtered_reg;
        diff_dn     = filtered_reg - sample;
        round_mask  = ({{ALT_W{1'b0}}, 1'b1} << cfg.filter_shift) - {{ALT_W{1'b0}}, 1'b1};
        diff_dn_rnd = ({1'b0, diff_dn} + round_mask) >> cfg.filter_shift;
        if (sample >= filtered_reg)
        begin
            filt_upd = filtered_reg + (diff_up >> cfg.filter_shift);
        end
        else
        begin
            filt_upd = filtered_reg - diff_dn_rnd[ALT_W-1:0];
        end
    end

    // Elapsed time accumulates with saturation at its full width.
    always_comb
    begin
        elapsed_sum = {1'b0, elapsed_us_reg} + {{(ELAPSED_W+1-COUNT_W){1'b0}}, event_count};
        if (elapsed_sum[ELAPSED_W])
        begin
            elapsed_sat = '1;
        end
        else
        begin
            elapsed_sat = elapsed_sum[ELAPSED_W-1:0];
        end
    end

    // Next state for the item being processed.
    always_comb
    begin
        edge_phase_next  = edge_phase_reg;
        rise_time_next   = rise_time_reg;
        elapsed_us_next  = elapsed_us_reg;
        filtered_next    = filtered_reg;
        capture_cnt_next = capture_cnt_reg;
        if (req_type == REQ_OVERFLOW)
        begin
            if (elapsed_sat >= {1'b0, cfg.timeout_us})
            begin
                edge_phase_next = 1'b0;
                rise_time_next  = '0;
                elapsed_us_next = '0;
            end
            else
            begin
                elapsed_us_next = elapsed_sat;
            end
        end
        else if (!edge_phase_reg)
        begin
            rise_time_next  = event_count;
            elapsed_us_next = '0;
            edge_phase_next = 1'b1;
        end
        else
        begin
            edge_phase_next  = 1'b0;
            capture_cnt_next = capture_cnt_reg + 1'b1;
            if (inr)
            begin
                filtered_next = filt_upd;
            end
        end
    end

    // Capture state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_phase_reg  <= 1'b0;
            rise_time_reg   <= '0;
            elapsed_us_reg  <= '0;
            filtered_reg    <= '0;
            capture_cnt_reg <= '0;
        end
        else if (fire)
        begin
            edge_phase_reg  <= edge_phase_next;
            rise_time_reg   <= rise_time_next;
            elapsed_us_reg  <= elapsed_us_next;
            filtered_reg    <= filtered_next;
            capture_cnt_reg <= capture_cnt_next;
        end
    end

    // Result of a falling edge.
    assign res_valid         = is_fall;
    assign res.pulse_us      = width;
    assign res.in_range      = inr;
    assign res.too_close     = close;
    assign res.altitude      = close ? '0 : filtered_next;
    assign res.capture_total = capture_cnt_next;

endmodule
